### src/ipcs_pkg.sv
// Shared item types and checksum kind codes for the IP transport checksum engine.
`timescale 1ns / 1ps

package ipcs_pkg;

	// One packet byte with its framing marks and the checksum kind.
	typedef struct packed {
		logic [2:0] func;
		logic [7:0] data_byte;
		logic       first;
		logic       last;
	} in_item_t;

	// One checksum result.
	typedef struct packed {
		logic [15:0] checksum_value;
		logic        status;
	} out_item_t;

	// Checksum kind codes carried in func on the first byte.
	localparam logic [2:0] KIND_IPV4_HDR = 3'd0;
	localparam logic [2:0] KIND_TCP      = 3'd1;
	localparam logic [2:0] KIND_UDP      = 3'd2;
	localparam logic [2:0] KIND_ICMPV4   = 3'd3;
	localparam logic [2:0] KIND_ICMPV6   = 3'd4;

	// Status codes.
	localparam logic STATUS_OK          = 1'b0;
	localparam logic STATUS_BAD_VERSION = 1'b1;

endpackage

### src/ipcs_in_stage.sv
// Input register stage: holds one accepted item until the core consumes it.
`timescale 1ns / 1ps

module ipcs_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  ipcs_pkg::in_item_t req,
	input  logic               advance,
	output logic               item_valid_s1,
	output ipcs_pkg::in_item_t item_s1
);

	// Take a new item when the stage is empty or drains this cycle.
	assign req_ready = !item_valid_s1 || advance;

	// Track occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	// Hold the payload.
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

endmodule

### src/ipcs_sum_core.sv
// Header parse, one's complement accumulation and final checksum for each byte.
`timescale 1ns / 1ps

module ipcs_sum_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  ipcs_pkg::in_item_t  item,
	output ipcs_pkg::out_item_t result
);

	localparam logic [15:0] V6_ADDR_LO = 16'd8;
	localparam logic [15:0] V6_ADDR_HI = 16'd40;
	localparam logic [15:0] V4_ADDR_LO = 16'd12;
	localparam logic [15:0] V4_ADDR_HI = 16'd20;
	localparam logic [15:0] V4_CKS_OFF = 16'd10;
	localparam logic [15:0] V6_PROTO_OFF = 16'd6;
	localparam logic [15:0] V4_PROTO_OFF = 16'd9;
	localparam logic [15:0] TCP_CKS_OFF  = 16'd16;
	localparam logic [15:0] UDP_CKS_OFF  = 16'd6;
	localparam logic [15:0] ICMP_CKS_OFF = 16'd2;
	localparam logic [7:0]  V6_HDR_BYTES = 8'd40;
	localparam logic [3:0]  VERSION_4 = 4'd4;
	localparam logic [3:0]  VERSION_6 = 4'd6;

	// 16-bit one's complement add with end-around carry.
	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] t;
		begin
			t = {1'b0, a} + {1'b0, b};
			ones_add = t[15:0] + {15'd0, t[16]};
		end
	endfunction

	logic [15:0] sum_q;
	logic [15:0] off_q;
	logic [7:0]  hb_q;
	logic        v6_q;
	logic        bad_q;
	logic [7:0]  held_q;
	logic [2:0]  kind_q;
	logic [7:0]  proto_q;

	logic [15:0] e_sum;
	logic [15:0] e_off;
	logic [7:0]  e_hb;
	logic        e_v6;
	logic        e_bad;
	logic [7:0]  e_held;
	logic [2:0]  e_kind;
	logic [7:0]  e_proto;
	logic [3:0]  ver;

	logic [15:0] w;
	logic [15:0] word_val;
	logic [15:0] seg_off;
	logic [15:0] cks_off;
	logic        pseudo_use;
	logic        ph_hit;
	logic        cov;
	logic        take;
	logic [15:0] addend;
	logic [15:0] sum_a;
	logic [15:0] sum_b;
	logic [15:0] sum_c;
	logic [16:0] count;
	logic [16:0] seg_full;
	logic [15:0] seg_len;
	logic [7:0]  n_proto;
	logic [7:0]  n_held;

	// Pick the packet context: fresh on a first byte, else carried.
	always_comb begin
		ver = item.data_byte[7:4];
		if (item.first) begin
			e_sum   = 16'd0;
			e_off   = 16'd0;
			e_kind  = item.func;
			e_v6    = (ver == VERSION_6);
			e_bad   = (ver != VERSION_4) && (ver != VERSION_6);
			e_hb    = e_v6 ? V6_HDR_BYTES : {2'b00, item.data_byte[3:0], 2'b00};
			e_held  = 8'd0;
			e_proto = 8'd0;
		end else begin
			e_sum   = sum_q;
			e_off   = off_q;
			e_kind  = kind_q;
			e_v6    = v6_q;
			e_bad   = bad_q;
			e_hb    = hb_q;
			e_held  = held_q;
			e_proto = proto_q;
		end
	end

	// Weigh the word that this byte completes and form its addend.
	always_comb begin
		w        = {e_off[15:1], 1'b0};
		word_val = e_off[0] ? {e_held, item.data_byte} : {item.data_byte, 8'd0};
		seg_off  = w - {8'd0, e_hb};
		case (e_kind)
			ipcs_pkg::KIND_TCP: cks_off = TCP_CKS_OFF;
			ipcs_pkg::KIND_UDP: cks_off = UDP_CKS_OFF;
			default:            cks_off = ICMP_CKS_OFF;
		endcase
		pseudo_use = !e_bad &&
			(e_kind == ipcs_pkg::KIND_TCP || e_kind == ipcs_pkg::KIND_UDP ||
			e_kind == ipcs_pkg::KIND_ICMPV6);
		ph_hit = e_v6 ? (w >= V6_ADDR_LO && w < V6_ADDR_HI)
			: (w >= V4_ADDR_LO && w < V4_ADDR_HI);
		case (e_kind) inside
			ipcs_pkg::KIND_IPV4_HDR:
				cov = (w < {8'd0, e_hb}) && !(!e_v6 && w == V4_CKS_OFF);
			ipcs_pkg::KIND_TCP, ipcs_pkg::KIND_UDP, ipcs_pkg::KIND_ICMPV4,
			ipcs_pkg::KIND_ICMPV6:
				cov = (w >= {8'd0, e_hb}) && (seg_off != cks_off);
			default:       cov = 1'b0;
		endcase
		take = e_off[0] || item.last;
		// A doubled word is a one-bit left rotate in one's complement.
		if (!take) begin
			addend = 16'd0;
		end else if (pseudo_use && ph_hit && cov) begin
			addend = {word_val[14:0], word_val[15]};
		end else if ((pseudo_use && ph_hit) || cov) begin
			addend = word_val;
		end else begin
			addend = 16'd0;
		end
	end

	// Add the word, then the pseudo-header tail on a last byte when the pseudo-header is used.
	always_comb begin
		n_proto = ((e_v6 && e_off == V6_PROTO_OFF) || (!e_v6 && e_off == V4_PROTO_OFF))
			? item.data_byte : e_proto;
		n_held   = e_off[0] ? e_held : item.data_byte;
		count    = {1'b0, e_off} + 17'd1;
		seg_full = count - {9'd0, e_hb};
		seg_len  = (count >= {9'd0, e_hb}) ? seg_full[15:0] : 16'd0;
		sum_a    = ones_add(e_sum, addend);
		if (item.last && pseudo_use) begin
			sum_b = ones_add(sum_a, {8'd0, n_proto});
			sum_c = ones_add(sum_b, seg_len);
		end else begin
			sum_b = sum_a;
			sum_c = sum_a;
		end
		if (e_bad) begin
			result.checksum_value = 16'd0;
			result.status         = ipcs_pkg::STATUS_BAD_VERSION;
		end else begin
			result.checksum_value = ~sum_c;
			result.status         = ipcs_pkg::STATUS_OK;
		end
	end

	// Advance the packet context on each consumed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q   <= 16'd0;
			off_q   <= 16'd0;
			hb_q    <= 8'd0;
			v6_q    <= 1'b0;
			bad_q   <= 1'b0;
			held_q  <= 8'd0;
			kind_q  <= ipcs_pkg::KIND_IPV4_HDR;
			proto_q <= 8'd0;
		end else if (fire) begin
			sum_q   <= sum_c;
			off_q   <= e_off + 16'd1;
			hb_q    <= e_hb;
			v6_q    <= e_v6;
			bad_q   <= e_bad;
			held_q  <= n_held;
			kind_q  <= e_kind;
			proto_q <= n_proto;
		end
	end

endmodule

### src/ip_transport_checksum_engine.sv
// Top level of the IP transport checksum engine: input stage, core, result register.
//
// Usage: feed a packet one byte per item on req, starting at the IP header.
// The item with first set carries the checksum kind in func (IPv4 header, TCP,
// UDP, ICMPv4, ICMPv6) and the version/IHL byte. The item with last set ends
// the covered bytes and produces exactly one item on rsp: the inverted folded
// one's complement sum, or status 1 with value 0 when the version is not 4 or 6.
// Items without last produce no result.
// Throughput: one byte per cycle, sustained while no last byte waits on a full
// result slot; the per-byte sum update is a short chain of 16-bit one's complement
// adders between the input stage and the context registers.
// Result: rsp_valid rises at the clock edge at which the core consumes the
// last byte from the input stage; the byte is first registered there and may
// wait in that stage while the result slot is full.
// Reset: arst_n clears the valid flags of both stages and the packet context (sum, offset,
// header fields) to zero.
// Stall: while a result waits on rsp_ready, bytes without last keep flowing;
// a second last byte waits in the input stage and req_ready drops.
`timescale 1ns / 1ps

module ip_transport_checksum_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  ipcs_pkg::in_item_t  req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output ipcs_pkg::out_item_t rsp
);

	logic                item_valid_s1;
	ipcs_pkg::in_item_t  item_s1;
	logic                advance;
	ipcs_pkg::out_item_t result;
	logic                rsp_valid_q;
	ipcs_pkg::out_item_t rsp_q;

	// Drain the input stage unless a last byte meets a full result slot that is not being taken.
	assign advance = item_valid_s1 && (!item_s1.last || !rsp_valid_q || rsp_ready);

	ipcs_in_stage u_in_stage (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.req           (req),
		.advance       (advance),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1)
	);

	ipcs_sum_core u_sum_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.result (result)
	);

	// Load the result on a last byte, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance && item_s1.last) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last) begin
			rsp_q <= result;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A last byte leaves the input stage only into a free result slot.
	a_last_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.last) |-> (!rsp_valid_q || rsp_ready))
		else $error("last byte consumed while result slot full");

	// A result appears only after a last byte was consumed.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		(!rsp_valid_q ##1 rsp_valid_q) |-> $past(advance && item_s1.last))
		else $error("result without a consumed last byte");

	// A bad version result always carries a zero value.
	a_bad_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.status == ipcs_pkg::STATUS_BAD_VERSION)
		|-> (rsp_q.checksum_value == 16'd0))
		else $error("bad version result with nonzero value");

endmodule

### tb/ip_transport_checksum_engine_test.sv
// Testbench for the IP transport checksum engine: byte stream stimulus, sum prediction, result check.
`timescale 1ns / 1ps

module ip_transport_checksum_engine_test;

	localparam int RANDOM_BYTES  = 650;
	localparam int STALL_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int HOLD_CYCLES   = 400;

	// Header and segment offsets that steer the sum
	localparam int V4_CKS_OFF    = 10;
	localparam int V4_PROTO_OFF  = 9;
	localparam int V6_NEXT_OFF   = 6;
	localparam int V4_ADDR_LO    = 12;
	localparam int V4_ADDR_HI    = 20;
	localparam int V6_ADDR_LO    = 8;
	localparam int V6_HDR_BYTES  = 40;
	localparam int TCP_CKS_OFF   = 16;
	localparam int UDP_CKS_OFF   = 6;
	localparam int ICMP_CKS_OFF  = 2;
	localparam logic [3:0] IP_V4 = 4'd4;
	localparam logic [3:0] IP_V6 = 4'd6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                req_valid = 1'b0;
	logic                req_ready;
	ipcs_pkg::in_item_t  req = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	ipcs_pkg::out_item_t rsp;

	// Predicted packet context
	logic [31:0] ctx_sum = '0;
	logic [15:0] ctx_off = '0;
	logic [7:0]  ctx_hdr_len = '0;
	bit          ctx_v6 = 1'b0;
	bit          ctx_bad = 1'b0;
	logic [7:0]  ctx_hi = '0;
	logic [2:0]  ctx_kind = '0;
	logic [7:0]  ctx_proto = '0;

	ipcs_pkg::out_item_t checksum_queue[$];
	logic [7:0]  pkt_bytes[$];
	int          bytes_sent = 0;
	int          errors = 0;
	int          quiet_cycles = 0;
	int          rsp_hold = 0;
	bit          tx_idle_on = 1'b1;

	ip_transport_checksum_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #5 clk = ~clk;

	// One's complement add with end-around carry on 32 bits
	function automatic void sum_word(input logic [31:0] w);
		logic [32:0] s;
		s = {1'b0, ctx_sum} + {1'b0, w};
		ctx_sum = s[31:0] + {31'd0, s[32]};
	endfunction

	function automatic bit pseudo_on();
		return !ctx_bad && (ctx_kind == ipcs_pkg::KIND_TCP ||
			ctx_kind == ipcs_pkg::KIND_UDP || ctx_kind == ipcs_pkg::KIND_ICMPV6);
	endfunction

	// Count the roles (pseudo-header, covered bytes) of the word at even offset w
	function automatic int unsigned word_count(input int unsigned w);
		int unsigned n;
		int unsigned hb;
		int unsigned cks;
		n = 0;
		hb = ctx_hdr_len;
		if (pseudo_on()) begin
			if (ctx_v6 ? (w >= V6_ADDR_LO && w < V6_HDR_BYTES) :
				(w >= V4_ADDR_LO && w < V4_ADDR_HI))
				n++;
		end
		if (ctx_kind == ipcs_pkg::KIND_IPV4_HDR) begin
			if (w < hb && !(!ctx_v6 && w == V4_CKS_OFF))
				n++;
		end else if (ctx_kind <= ipcs_pkg::KIND_ICMPV6) begin
			cks = (ctx_kind == ipcs_pkg::KIND_TCP) ? TCP_CKS_OFF :
				(ctx_kind == ipcs_pkg::KIND_UDP) ? UDP_CKS_OFF : ICMP_CKS_OFF;
			if (w >= hb && (w - hb) != cks)
				n++;
		end
		return n;
	endfunction

	function automatic void add_covered(input int unsigned w, input logic [31:0] value);
		repeat (word_count(w)) sum_word(value);
	endfunction

	// Advance the packet context by one byte; return 1 with the checksum on a last byte
	function automatic bit predict_checksum(input ipcs_pkg::in_item_t it,
		output ipcs_pkg::out_item_t res);
		logic [3:0]  ver;
		int unsigned off;
		int unsigned count;
		int unsigned seg;
		logic [31:0] s;
		res = '0;
		if (it.first) begin
			ver = it.data_byte[7:4];
			ctx_sum = '0;
			ctx_off = '0;
			ctx_kind = it.func;
			ctx_v6 = (ver == IP_V6);
			ctx_bad = (ver != IP_V4 && ver != IP_V6);
			ctx_hdr_len = ctx_v6 ? 8'(V6_HDR_BYTES) : {2'b00, it.data_byte[3:0], 2'b00};
			ctx_hi = '0;
			ctx_proto = '0;
		end
		off = ctx_off;
		if ((ctx_v6 && off == V6_NEXT_OFF) || (!ctx_v6 && off == V4_PROTO_OFF))
			ctx_proto = it.data_byte;
		if (off[0]) begin
			add_covered(off - 1, {16'd0, ctx_hi, it.data_byte});
		end else begin
			ctx_hi = it.data_byte;
			if (it.last)
				add_covered(off, {16'd0, it.data_byte, 8'h00});
		end
		ctx_off = ctx_off + 16'd1;
		if (!it.last)
			return 1'b0;
		if (ctx_bad) begin
			res.checksum_value = '0;
			res.status = ipcs_pkg::STATUS_BAD_VERSION;
			return 1'b1;
		end
		if (pseudo_on()) begin
			count = off + 1;
			seg = (count >= ctx_hdr_len) ? ((count - ctx_hdr_len) & 32'hFFFF) : 0;
			sum_word({24'd0, ctx_proto});
			sum_word(seg);
		end
		s = ctx_sum;
		while (s[31:16] != 0)
			s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
		res.checksum_value = ~s[15:0];
		res.status = ipcs_pkg::STATUS_OK;
		return 1'b1;
	endfunction

	// Sender idle length: mostly none, some short, a few long
	function automatic int tx_gap();
		int r;
		if (!tx_idle_on)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one item and hold it until accepted
	task automatic send_byte(input logic [2:0] f, input logic [7:0] b, input bit fst,
		input bit lst);
		ipcs_pkg::in_item_t  it;
		ipcs_pkg::out_item_t res;
		int                  gap;
		it.func = f;
		it.data_byte = b;
		it.first = fst;
		it.last = lst;
		gap = tx_gap();
		@(negedge clk);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		bytes_sent++;
		if (predict_checksum(it, res))
			checksum_queue.push_back(res);
	endtask

	// Fill pkt_bytes with a header of the given version and length plus a segment
	task automatic build_packet(input logic [3:0] ver, input logic [3:0] ihl, input int seg_len);
		int total;
		pkt_bytes.delete();
		total = ((ver == IP_V6) ? V6_HDR_BYTES : ihl * 4) + seg_len;
		if (total < 1)
			total = 1;
		repeat (total) pkt_bytes.push_back(8'($urandom_range(0, 255)));
		pkt_bytes[0] = {ver, ihl};
	endtask

	// Stream pkt_bytes with first on byte 0 and optionally last on the final byte
	task automatic send_packet(input logic [2:0] f, input bit with_last);
		for (int i = 0; i < pkt_bytes.size(); i++)
			send_byte((i == 0) ? f : 3'($urandom_range(0, 7)), pkt_bytes[i], i == 0,
				with_last && i == pkt_bytes.size() - 1);
	endtask

	task automatic fill_packet(input logic [7:0] b);
		for (int i = 1; i < pkt_bytes.size(); i++)
			pkt_bytes[i] = b;
	endtask

	// Bytes before any first byte continue the reset context
	task automatic test_bytes_before_first();
		send_byte(ipcs_pkg::KIND_TCP, 8'hFF, 1'b0, 1'b0);
		send_byte(ipcs_pkg::KIND_UDP, 8'h00, 1'b0, 1'b1);
	endtask

	// Cover every kind, the field extremes and the odd corners of parsing
	task automatic test_directed_cases();
		send_byte(ipcs_pkg::KIND_IPV4_HDR, 8'h45, 1'b1, 1'b1);
		build_packet(IP_V4, 4'd5, 0);
		fill_packet(8'hFF);
		send_packet(ipcs_pkg::KIND_IPV4_HDR, 1'b1);
		build_packet(IP_V4, 4'd5, 20);
		fill_packet(8'h00);
		send_packet(ipcs_pkg::KIND_TCP, 1'b1);
		build_packet(IP_V4, 4'd5, 9);
		send_packet(ipcs_pkg::KIND_UDP, 1'b1);
		build_packet(IP_V4, 4'd5, 8);
		fill_packet(8'hFF);
		send_packet(ipcs_pkg::KIND_ICMPV4, 1'b1);
		build_packet(IP_V6, 4'd0, 8);
		send_packet(ipcs_pkg::KIND_ICMPV6, 1'b1);
		build_packet(IP_V6, 4'd15, 7);
		send_packet(ipcs_pkg::KIND_UDP, 1'b1);
		build_packet(IP_V6, 4'd3, 21);
		send_packet(ipcs_pkg::KIND_TCP, 1'b1);
		// short IPv4 headers overlap the address bytes with the segment
		build_packet(IP_V4, 4'd3, 10);
		send_packet(ipcs_pkg::KIND_TCP, 1'b1);
		build_packet(IP_V4, 4'd0, 5);
		send_packet(ipcs_pkg::KIND_UDP, 1'b1);
		build_packet(IP_V4, 4'd15, 3);
		send_packet(ipcs_pkg::KIND_IPV4_HDR, 1'b1);
		// IPv4 header kind over an IPv6 header
		build_packet(IP_V6, 4'd0, 0);
		send_packet(ipcs_pkg::KIND_IPV4_HDR, 1'b1);
		// unused kinds sum nothing
		for (int k = ipcs_pkg::KIND_ICMPV6 + 1; k < 8; k++) begin
			build_packet(IP_V4, 4'd5, 4);
			send_packet(3'(k), 1'b1);
		end
		// bad versions at both ends of the nibble
		build_packet(4'd0, 4'd5, 4);
		send_packet(ipcs_pkg::KIND_TCP, 1'b1);
		build_packet(4'd15, 4'd15, 3);
		send_packet(ipcs_pkg::KIND_UDP, 1'b1);
		// bytes after a last byte keep adding to the same packet
		build_packet(IP_V4, 4'd5, 2);
		send_packet(ipcs_pkg::KIND_UDP, 1'b1);
		send_byte(ipcs_pkg::KIND_ICMPV4, 8'hA5, 1'b0, 1'b0);
		send_byte(ipcs_pkg::KIND_ICMPV4, 8'h5A, 1'b0, 1'b1);
		// last inside the header
		build_packet(IP_V4, 4'd5, 0);
		pkt_bytes = pkt_bytes[0:9];
		send_packet(ipcs_pkg::KIND_TCP, 1'b1);
	endtask

	// Hold the result side off while short packets keep coming
	task automatic test_result_backpressure();
		tx_idle_on = 1'b0;
		rsp_hold = HOLD_CYCLES;
		repeat (12) begin
			build_packet(IP_V4, 4'd1, 0);
			send_packet(ipcs_pkg::KIND_IPV4_HDR, 1'b1);
		end
		tx_idle_on = 1'b1;
	endtask

	// Mostly well-formed packets with random content, some noise and broken framing
	task automatic test_random_packets();
		int          start_bytes;
		int          r;
		logic [2:0]  kind;
		logic [3:0]  ver;
		logic [3:0]  ihl;
		int          seg_len;
		start_bytes = bytes_sent;
		while (bytes_sent - start_bytes < RANDOM_BYTES) begin
			tx_idle_on = ($urandom_range(0, 3) != 0);
			kind = ($urandom_range(0, 99) < 94) ? 3'($urandom_range(0, 4)) :
				3'($urandom_range(5, 7));
			r = $urandom_range(0, 99);
			ver = (r < 50) ? IP_V4 : (r < 85) ? IP_V6 : 4'($urandom_range(0, 15));
			ihl = ($urandom_range(0, 99) < 60) ? 4'd5 : 4'($urandom_range(0, 15));
			if (kind == ipcs_pkg::KIND_IPV4_HDR)
				seg_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : 0;
			else
				seg_len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 80) :
					$urandom_range(0, 24);
			build_packet(ver, ihl, seg_len);
			r = $urandom_range(0, 99);
			if (r < 85) begin
				send_packet(kind, 1'b1);
			end else if (r < 92) begin
				// truncated: the next first byte restarts the context
				send_packet(kind, 1'b0);
			end else if (r < 96) begin
				repeat ($urandom_range(1, 4))
					send_byte(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0,
						$urandom_range(0, 3) == 0);
			end else begin
				send_packet(kind, 1'b1);
				repeat ($urandom_range(0, 3))
					send_byte(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0,
						1'b0);
				send_byte(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 1'b0, 1'b1);
			end
		end
		tx_idle_on = 1'b1;
	endtask

	// Drive rsp_ready: random stall modes, or a counted hold when requested
	initial begin
		int mode;
		int left;
		mode = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ready <= 1'b0;
				rsp_hold--;
			end else begin
				if (left == 0) begin
					mode = $urandom_range(0, 3);
					left = $urandom_range(20, 120);
				end
				left--;
				case (mode)
					0: begin
						rsp_ready <= 1'b1;
					end
					1: begin
						rsp_ready <= ($urandom_range(0, 3) != 0);
					end
					2: begin
						rsp_ready <= ($urandom_range(0, 1) != 0);
					end
					default: begin
						rsp_ready <= ($urandom_range(0, 9) == 0);
					end
				endcase
			end
		end
	end

	// Compare each accepted result with the oldest predicted checksum
	always @(posedge clk) begin
		ipcs_pkg::out_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (checksum_queue.size() == 0) begin
				$error("unexpected result: checksum_value %h status %0d",
					rsp.checksum_value, rsp.status);
				errors++;
			end else begin
				want = checksum_queue.pop_front();
				if (rsp.checksum_value !== want.checksum_value) begin
					$error("checksum_value: expected %h, actual %h",
						want.checksum_value, rsp.checksum_value);
					errors++;
				end
				if (rsp.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, rsp.status);
					errors++;
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_bytes_before_first();
		test_directed_cases();
		test_result_backpressure();
		test_random_packets();
		@(negedge clk);
		req_valid <= 1'b0;
		while (checksum_queue.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
